[src/qphd_pkg.sv]
`timescale 1ns / 1ps
package qphd_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int ELEM_W     = 8;
  localparam int QUAD_W     = 11;
  localparam int LIN_W      = 25;
  localparam int CONST_W    = 25;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int PREFIX_W   = 32;
  localparam int WORD_W     = 64;
  localparam int HALF_W     = 32;
  localparam int PROD_W     = 128;

  localparam logic [CFG_IDX_W-1:0] REG_QUAD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONST = 2'd2;

endpackage

[src/qphd_in_if.sv]
`timescale 1ns / 1ps
interface qphd_in_if import qphd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;
  logic              is_last;

  modport source (output valid, element, is_last, input ready);
  modport sink (input valid, element, is_last, output ready);
endinterface

[src/qphd_out_if.sv]
`timescale 1ns / 1ps
interface qphd_out_if import qphd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] best_total;
  logic                     final_res;
  logic                     overflow;

  modport source (output valid, best_total, final_res, overflow, input ready);
  modport sink (input valid, best_total, final_res, overflow, output ready);
endinterface

[src/qphd_ram.sv]
`timescale 1ns / 1ps
module qphd_ram import qphd_pkg::*; #(
  parameter int WIDTH = PREFIX_W + WORD_W,
  parameter int DEPTH = DEPTH_DEF + 1,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/qphd_mul.sv]
`timescale 1ns / 1ps
module qphd_mul import qphd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] op_a,
  input  logic [WORD_W-1:0] op_b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic              busy;
  logic              fix;
  logic [1:0]        step;
  logic [WORD_W-1:0] mx;
  logic [WORD_W-1:0] my;
  logic              neg;
  logic [PROD_W-1:0] acc;

  logic [HALF_W-1:0] a_part;
  logic [HALF_W-1:0] b_part;
  logic [WORD_W-1:0] pp;
  logic [1:0]        sh;
  logic [PROD_W-1:0] pp_sh;

  // One 32x32 partial product of the magnitudes per cycle, shifted into place.
  always_comb begin
    a_part = step[0] ? mx[WORD_W-1:HALF_W] : mx[HALF_W-1:0];
    b_part = step[1] ? my[WORD_W-1:HALF_W] : my[HALF_W-1:0];
    pp     = WORD_W'(a_part) * WORD_W'(b_part);
    sh     = {1'b0, step[0]} + {1'b0, step[1]};
    pp_sh  = {{(PROD_W-WORD_W){1'b0}}, pp} << {sh, 5'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mx   <= op_a[WORD_W-1] ? (~op_a + WORD_W'(1)) : op_a;
        my   <= op_b[WORD_W-1] ? (~op_b + WORD_W'(1)) : op_b;
        neg  <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
        acc  <= '0;
        step <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        acc  <= acc + pp_sh;
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        prod <= neg ? (~acc + PROD_W'(1)) : acc;
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

[src/quadratic_partition_hull_dp.sv]
`timescale 1ns / 1ps
// Partition DP by the convex hull trick: one element per input transaction, one result
// per element giving the best total score of the prefix that ends there. Each item
// runs on a single shared 64x64 multiplier that forms four 32x32 partial products per
// product, used for the best value and for each front and back candidate test. The hull
// lives in one memory of DEPTH+1 entries read one entry per cycle; no clearing pass is
// needed. After the transaction marked is_last the block returns to its reset state
// while keeping its coefficient registers. Past DEPTH elements in a sequence, each
// result is zero with overflow set.
module quadratic_partition_hull_dp import qphd_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  qphd_in_if.sink               in_ch,
  qphd_out_if.source            out_ch
);

  localparam int CW = $clog2(DEPTH + 2);
  localparam int AW = $clog2(DEPTH + 1);
  localparam int RW = PREFIX_W + WORD_W;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_FCHK  = 23'h000002,
    S_FRD1  = 23'h000004,
    S_FRD2  = 23'h000008,
    S_SL1   = 23'h000010,
    S_SL2   = 23'h000020,
    S_SL3   = 23'h000040,
    S_SL4   = 23'h000080,
    S_SL5   = 23'h000100,
    S_FCMP  = 23'h000200,
    S_BRD   = 23'h000400,
    S_BM1   = 23'h000800,
    S_BM2   = 23'h001000,
    S_BM3   = 23'h002000,
    S_KCHK  = 23'h004000,
    S_KRD1  = 23'h008000,
    S_KRD2  = 23'h010000,
    S_KCMP1 = 23'h020000,
    S_KCMP2 = 23'h040000,
    S_PUSH  = 23'h080000,
    S_EMIT  = 23'h100000,
    S_SPARE = 23'h200000,
    S_HOLD  = 23'h400000
  } state_t;

  typedef enum logic [2:0] {
    PH_FRONT = 3'b001,
    PH_BACK1 = 3'b010,
    PH_BACK2 = 3'b100
  } phase_t;

  state_t state;
  phase_t phase;

  logic signed [QUAD_W-1:0]  quad_coef;
  logic signed [LIN_W-1:0]   lin_coef;
  logic signed [CONST_W-1:0] const_coef;

  logic [PREFIX_W-1:0] running_prefix;
  logic [CW-1:0]       hull_head;
  logic [CW-1:0]       hull_tail;
  logic [CW-1:0]       element_count;
  logic                ovf;
  logic                last;

  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] p1;
  logic [WORD_W-1:0] d1;
  logic [WORD_W-1:0] p2;
  logic [WORD_W-1:0] d2;
  logic [WORD_W-1:0] qp;
  logic [WORD_W-1:0] qd;
  logic [WORD_W-1:0] num;
  logic [WORD_W-1:0] den;
  logic [WORD_W-1:0] n1;
  logic [WORD_W-1:0] dn1;
  logic [WORD_W-1:0] best;
  logic [PROD_W-1:0] lhs;

  logic                     out_valid;
  logic signed [WORD_W-1:0] out_best;
  logic                     out_final;
  logic                     out_ovf;

  logic              mul_wait;
  logic              mul_start;
  logic              mul_done;
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic              is_mul_state;
  logic              skip_mul;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_q;
  logic          rd_zero;
  logic [WORD_W-1:0] rd_p;
  logic [WORD_W-1:0] rd_d;

  logic [WORD_W-1:0] a_ext;
  logic [WORD_W-1:0] b_ext;
  logic [WORD_W-1:0] c_ext;
  logic [WORD_W-1:0] dp;
  logic [WORD_W-1:0] t;
  logic [CW-1:0]     tail_m1;
  logic [CW-1:0]     tail_m2;
  logic [CW-1:0]     head_p1;
  logic              front_more;
  logic [PROD_W-1:0] num_wide;
  logic              slope_le;
  logic              slope_lt;

  assign a_ext   = {{(WORD_W-QUAD_W){quad_coef[QUAD_W-1]}}, quad_coef};
  assign b_ext   = {{(WORD_W-LIN_W){lin_coef[LIN_W-1]}}, lin_coef};
  assign c_ext   = {{(WORD_W-CONST_W){const_coef[CONST_W-1]}}, const_coef};
  assign dp      = p2 - p1;
  assign t       = x - p1;
  assign tail_m1 = hull_tail - CW'(1);
  assign tail_m2 = hull_tail - CW'(2);
  assign head_p1 = hull_head + CW'(1);
  assign front_more = (hull_tail - hull_head) > CW'(1);

  // Entry zero of the hull is the empty partition and always reads as zero.
  assign rd_p = rd_zero ? '0 : {{(WORD_W-PREFIX_W){1'b0}}, ram_q[RW-1:WORD_W]};
  assign rd_d = rd_zero ? '0 : ram_q[WORD_W-1:0];

  assign num_wide = {{(PROD_W-WORD_W){num[WORD_W-1]}}, num};
  assign slope_le = den[WORD_W-1] ? ($signed(num_wide) >= $signed(prod))
                                  : ($signed(prod) >= $signed(num_wide));
  assign slope_lt = (dn1[WORD_W-1] == den[WORD_W-1]) ? ($signed(lhs) < $signed(prod))
                                                     : ($signed(prod) < $signed(lhs));

  always_comb begin
    ram_raddr = hull_head[AW-1:0];
    unique case (state)
      S_FRD1:  ram_raddr = head_p1[AW-1:0];
      S_KCHK:  ram_raddr = tail_m1[AW-1:0];
      S_SL5:   ram_raddr = tail_m2[AW-1:0];
      default: ram_raddr = hull_head[AW-1:0];
    endcase
  end

  always_comb begin
    mul_a        = p2;
    mul_b        = p2;
    is_mul_state = 1'b1;
    skip_mul     = 1'b0;
    unique case (state)
      S_SL1: begin
        mul_a = p2;
        mul_b = p2;
      end
      S_SL2: begin
        mul_a = p1;
        mul_b = p1;
      end
      S_SL3, S_BM2: begin
        mul_a = a_ext;
        mul_b = num;
      end
      S_SL4: begin
        mul_a = b_ext;
        mul_b = dp;
      end
      S_SL5: begin
        mul_a = a_ext;
        mul_b = dp;
      end
      S_FCMP: begin
        mul_a    = x;
        mul_b    = den;
        skip_mul = (den == '0);
      end
      S_BM1: begin
        mul_a = t;
        mul_b = t;
      end
      S_BM3: begin
        mul_a = b_ext;
        mul_b = t;
      end
      S_KCMP1: begin
        mul_a    = n1;
        mul_b    = den;
        skip_mul = (dn1 == '0) || (den == '0);
      end
      S_KCMP2: begin
        mul_a = num;
        mul_b = dn1;
      end
      default: is_mul_state = 1'b0;
    endcase
  end

  assign mul_start = is_mul_state && !mul_wait && !skip_mul;
  assign ram_we    = (state == S_PUSH) && (hull_tail <= CW'(DEPTH));

  qphd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  qphd_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH + 1)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hull_tail[AW-1:0]),
    .wdata ({x[PREFIX_W-1:0], best}),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.best_total = out_best;
  assign out_ch.final_res  = out_final;
  assign out_ch.overflow   = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_coef  <= '1;
      lin_coef   <= '0;
      const_coef <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUAD:  quad_coef  <= cfg_data[QUAD_W-1:0];
        REG_LIN:   lin_coef   <= cfg_data[LIN_W-1:0];
        REG_CONST: const_coef <= cfg_data[CONST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_zero <= (ram_raddr == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_FRONT;
      running_prefix <= '0;
      hull_head      <= '0;
      hull_tail      <= CW'(1);
      element_count  <= '0;
      ovf            <= 1'b0;
      last           <= 1'b0;
      mul_wait       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      if (mul_start) begin
        mul_wait <= 1'b1;
      end else if (mul_done) begin
        mul_wait <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            last <= in_ch.is_last;
            if (element_count >= CW'(DEPTH) || ovf) begin
              ovf   <= 1'b1;
              best  <= '0;
              state <= S_EMIT;
            end else begin
              element_count  <= element_count + CW'(1);
              running_prefix <= running_prefix + PREFIX_W'(in_ch.element);
              x     <= {{(WORD_W-PREFIX_W){1'b0}},
                        running_prefix + PREFIX_W'(in_ch.element)};
              state <= S_FCHK;
            end
          end
        end
        S_FCHK: state <= front_more ? S_FRD1 : S_BRD;
        S_FRD1: begin
          p1    <= rd_p;
          d1    <= rd_d;
          state <= S_FRD2;
        end
        S_FRD2: begin
          p2    <= rd_p;
          d2    <= rd_d;
          phase <= PH_FRONT;
          state <= S_SL1;
        end
        S_SL1: if (mul_done) begin
          num   <= prod[WORD_W-1:0];
          state <= S_SL2;
        end
        S_SL2: if (mul_done) begin
          num   <= num - prod[WORD_W-1:0];
          state <= S_SL3;
        end
        S_SL3: if (mul_done) begin
          num   <= prod[WORD_W-1:0] + d2 - d1;
          state <= S_SL4;
        end
        S_SL4: if (mul_done) begin
          num   <= num - prod[WORD_W-1:0];
          state <= S_SL5;
        end
        S_SL5: if (mul_done) begin
          den <= {prod[WORD_W-2:0], 1'b0};
          unique case (phase)
            PH_FRONT: state <= S_FCMP;
            PH_BACK1: begin
              n1    <= num;
              dn1   <= {prod[WORD_W-2:0], 1'b0};
              state <= S_KRD2;
            end
            PH_BACK2: state <= S_KCMP1;
            default:  state <= S_FCMP;
          endcase
        end
        S_FCMP: begin
          if (skip_mul) begin
            state <= S_BM1;
          end else if (mul_done) begin
            if (slope_le) begin
              hull_head <= head_p1;
              state     <= S_FCHK;
            end else begin
              // p1 and d1 still hold the head entry.
              state <= S_BM1;
            end
          end
        end
        S_BRD: begin
          p1    <= rd_p;
          d1    <= rd_d;
          state <= S_BM1;
        end
        S_BM1: if (mul_done) begin
          num   <= prod[WORD_W-1:0];
          state <= S_BM2;
        end
        S_BM2: if (mul_done) begin
          num   <= prod[WORD_W-1:0] + d1 + c_ext;
          state <= S_BM3;
        end
        S_BM3: if (mul_done) begin
          best  <= num + prod[WORD_W-1:0];
          state <= S_KCHK;
        end
        S_KCHK: state <= front_more ? S_KRD1 : S_PUSH;
        S_KRD1: begin
          qp    <= rd_p;
          qd    <= rd_d;
          p1    <= rd_p;
          d1    <= rd_d;
          p2    <= x;
          d2    <= best;
          phase <= PH_BACK1;
          state <= S_SL1;
        end
        S_KRD2: begin
          p1    <= rd_p;
          d1    <= rd_d;
          p2    <= qp;
          d2    <= qd;
          phase <= PH_BACK2;
          state <= S_SL1;
        end
        S_KCMP1: begin
          if (skip_mul) begin
            state <= S_PUSH;
          end else if (mul_done) begin
            lhs   <= prod;
            state <= S_KCMP2;
          end
        end
        S_KCMP2: if (mul_done) begin
          if (slope_lt) begin
            hull_tail <= tail_m1;
            state     <= S_KCHK;
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (hull_tail <= CW'(DEPTH)) begin
            hull_tail <= hull_tail + CW'(1);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_best  <= best;
            out_final <= last;
            out_ovf   <= ovf;
            if (last) begin
              running_prefix <= '0;
              hull_head      <= '0;
              hull_tail      <= CW'(1);
              element_count  <= '0;
              ovf            <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import qphd_pkg::*;

  typedef logic signed [WORD_W-1:0] s64_t;
  typedef logic signed [PROD_W-1:0] s128_t;
  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              is_last;
  } elem_item_t;
  typedef struct packed {
    s64_t best_total;
    logic final_res;
    logic overflow;
  } score_t;

  localparam int HULL_DEPTH = DEPTH_DEF;
  localparam int STALL_LIMIT = 400000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  qphd_in_if in_ch ();
  qphd_out_if out_ch ();

  quadratic_partition_hull_dp i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  elem_item_t pending_elems[$];
  score_t expected_scores[$];
  int errs = 0;
  bit calm = 0;

  // Shadow copy of the coefficients and of the hull.
  s64_t quad_c, lin_c, const_c;
  logic [PREFIX_W-1:0] prefix_sum;
  logic [PREFIX_W-1:0] cand_prefix[0:HULL_DEPTH];
  s64_t cand_best[0:HULL_DEPTH];
  int unsigned head, tail, seen;
  bit ovf_sticky;

  function automatic void clear_hull();
    prefix_sum = '0;
    foreach (cand_prefix[i]) begin
      cand_prefix[i] = '0;
      cand_best[i] = '0;
    end
    head = 0;
    tail = 1;
    seen = 0;
    ovf_sticky = 0;
  endfunction

  function automatic void line_slope(input s64_t p1, input s64_t d1, input s64_t p2,
                                     input s64_t d2, output s64_t num, output s64_t den);
    s64_t dp;
    dp = p2 - p1;
    num = d2 - d1 - lin_c * dp + quad_c * (p2 * p2 - p1 * p1);
    den = s64_t'(2) * quad_c * dp;
  endfunction

  function automatic bit slope_at_most(input s64_t num, input s64_t den, input s64_t x);
    s128_t n, xd;
    if (den == 0) return 0;
    n = s128_t'(num);
    xd = s128_t'(x) * s128_t'(den);
    if (den < 0) return n >= xd;
    return xd >= n;
  endfunction

  function automatic bit slope_below(input s64_t n1, input s64_t d1, input s64_t n2,
                                     input s64_t d2);
    s128_t l, r;
    if (d1 == 0 || d2 == 0) return 0;
    l = s128_t'(n1) * s128_t'(d2);
    r = s128_t'(n2) * s128_t'(d1);
    if ((d1 < 0) == (d2 < 0)) return l < r;
    return r < l;
  endfunction

  function automatic score_t best_split(input elem_item_t it);
    score_t res;
    s64_t x, t, n1, d1, n2, d2, best;
    int unsigned q, r;
    best = '0;
    if (seen >= HULL_DEPTH || ovf_sticky) begin
      ovf_sticky = 1;
    end else begin
      seen++;
      prefix_sum = prefix_sum + PREFIX_W'(it.element);
      x = s64_t'({32'b0, prefix_sum});
      while (tail - head > 1 && head + 1 <= HULL_DEPTH) begin
        line_slope({32'b0, cand_prefix[head]}, cand_best[head],
                   {32'b0, cand_prefix[head+1]}, cand_best[head+1], n1, d1);
        if (!slope_at_most(n1, d1, x)) break;
        head++;
      end
      if (head > HULL_DEPTH) head = HULL_DEPTH;
      t = x - s64_t'({32'b0, cand_prefix[head]});
      best = cand_best[head] + quad_c * t * t + lin_c * t + const_c;
      while (tail - head > 1 && tail >= 2 && tail - 1 <= HULL_DEPTH) begin
        q = tail - 1;
        r = tail - 2;
        line_slope({32'b0, cand_prefix[q]}, cand_best[q], x, best, n1, d1);
        line_slope({32'b0, cand_prefix[r]}, cand_best[r],
                   {32'b0, cand_prefix[q]}, cand_best[q], n2, d2);
        if (!slope_below(n1, d1, n2, d2)) break;
        tail--;
      end
      if (tail <= HULL_DEPTH) begin
        cand_prefix[tail] = x[PREFIX_W-1:0];
        cand_best[tail] = best;
        tail++;
      end
    end
    res.best_total = best;
    res.final_res = it.is_last;
    res.overflow = ovf_sticky;
    if (it.is_last) clear_hull();
    return res;
  endfunction

  initial begin
    clk = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.element = '0;
    in_ch.is_last = 0;
    out_ch.ready = 0;
    forever #1 clk = ~clk;
  end

  // Input driver with random idle bursts.
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_scores.push_back(best_split('{in_ch.element, in_ch.is_last}));
        void'(pending_elems.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 0;
        end else if (pending_elems.size() == 0) begin
          in_ch.valid <= 0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 16);
          in_ch.valid <= 0;
        end else begin
          in_ch.valid <= 1;
          in_ch.element <= pending_elems[0].element;
          in_ch.is_last <= pending_elems[0].is_last;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  int sink_gap = 0;
  always @(posedge clk) begin
    score_t want;
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_scores.size() == 0) begin
          $error("unexpected result transaction, best_total %0d", out_ch.best_total);
          errs++;
        end else begin
          want = expected_scores.pop_front();
          if (out_ch.best_total !== want.best_total) begin
            $error("best_total: expected %0d, actual %0d", want.best_total, out_ch.best_total);
            errs++;
          end
          if (out_ch.final_res !== want.final_res) begin
            $error("final_res: expected %0d, actual %0d", want.final_res, out_ch.final_res);
            errs++;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, out_ch.overflow);
            errs++;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 16);
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input s64_t value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_QUAD:  quad_c = s64_t'($signed(value[QUAD_W-1:0]));
      REG_LIN:   lin_c = s64_t'($signed(value[LIN_W-1:0]));
      REG_CONST: const_c = s64_t'($signed(value[CONST_W-1:0]));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_coefs(input s64_t a, input s64_t b, input s64_t c);
    write_reg(REG_QUAD, a);
    write_reg(REG_LIN, b);
    write_reg(REG_CONST, c);
  endtask

  task automatic drain();
    wait (pending_elems.size() == 0 && expected_scores.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic void push_seq(input int len, input bit zeros, input int max_elem);
    elem_item_t it;
    for (int i = 0; i < len; i++) begin
      it.element = (zeros && $urandom_range(0, 9) == 0) ? '0
                 : ELEM_W'($urandom_range(1, max_elem));
      it.is_last = (i == len - 1);
      pending_elems.push_back(it);
    end
  endfunction

  function automatic s64_t rand_signed25();
    return s64_t'($signed(25'($urandom)));
  endfunction

  initial begin
    quad_c = -1;
    lin_c = 0;
    const_c = 0;
    clear_hull();
    repeat (4) @(posedge clk);
    rst <= 0;

    // Directed: single elements at the extremes, zero elements, a mixed run.
    pending_elems.push_back('{8'd1, 1'b1});
    pending_elems.push_back('{8'd255, 1'b1});
    pending_elems.push_back('{8'd0, 1'b1});
    pending_elems.push_back('{8'd255, 1'b0});
    pending_elems.push_back('{8'd255, 1'b0});
    pending_elems.push_back('{8'd1, 1'b0});
    pending_elems.push_back('{8'd0, 1'b0});
    pending_elems.push_back('{8'd128, 1'b0});
    pending_elems.push_back('{8'd1, 1'b0});
    pending_elems.push_back('{8'd170, 1'b0});
    pending_elems.push_back('{8'd85, 1'b1});
    drain();

    set_coefs(-1023, 16777215, -16777216);
    push_seq(6, 0, 255);
    pending_elems.push_back('{8'd255, 1'b1});
    drain();
    // A zero quadratic coefficient makes every slope denominator zero.
    set_coefs(0, -16777216, 16777215);
    push_seq(8, 1, 255);
    drain();

    // Overflow: more elements than the hull holds, in one sequence.
    set_coefs(-1, 3, -2);
    push_seq(HULL_DEPTH + 8, 0, 255);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) calm = 1;
      case (ph % 4)
        0: set_coefs(-s64_t'($urandom_range(1, 1023)), rand_signed25(), rand_signed25());
        1: set_coefs(-s64_t'($urandom_range(1, 8)), s64_t'($urandom_range(0, 4096)),
                     -s64_t'($urandom_range(0, 200000)));
        2: set_coefs(-1023, -16777216, 16777215);
        default: set_coefs(-s64_t'($urandom_range(1, 1023)), rand_signed25(),
                           s64_t'($urandom_range(0, 16777215)));
      endcase
      for (int n = 0; n < 64; ) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        push_seq(len, 1, ($urandom_range(0, 3) == 0) ? 7 : 255);
        n += len;
      end
      drain();
    end

    if (errs == 0 && expected_scores.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[sim.f]
src/qphd_pkg.sv
src/qphd_in_if.sv
src/qphd_out_if.sv
src/qphd_ram.sv
src/qphd_mul.sv
src/quadratic_partition_hull_dp.sv
tb/testbench.sv
